/* rtl/sts_pkg.sv */
// ----------------------------------------------------------------------------
// sts_pkg
// Shared constants, item type and small conversion functions for the
// subtitle timestamp shifter.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int unsigned STAMP_LEN = 8;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned SEC_W     = 19;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] ZERO_CHAR    = 8'h30;
  localparam logic [7:0] NINE_CHAR    = 8'h39;

  localparam logic [4:0] FIRST_END    = 5'd7;
  localparam logic [4:0] SECOND_START = 5'd17;
  localparam logic [4:0] SECOND_END   = 5'd24;
  localparam logic [4:0] POS_MAX      = 5'd31;

  localparam logic [1:0] STAMP_PHASE  = 2'd1;

  localparam logic [SEC_W-1:0] MAX_SECONDS  = 19'd359999;
  localparam logic [11:0]      SEC_PER_HOUR = 12'd3600;

  // floor(t / 3600) = (t * HOUR_RECIP) >> HOUR_SHIFT for t <= 359999
  localparam logic [19:0]  HOUR_RECIP = 20'd596524;
  localparam int unsigned  HOUR_SHIFT = 31;
  // floor(r / 60) = (r * MIN_RECIP) >> MIN_SHIFT for r < 3600
  localparam logic [12:0]  MIN_RECIP  = 13'd4370;
  localparam int unsigned  MIN_SHIFT  = 18;

  localparam logic CFG_OFFSET = 1'b0;
  localparam logic CFG_DIR    = 1'b1;
  localparam logic DIR_SUB    = 1'b1;

  typedef logic [STAMP_LEN-1:0][7:0] burst_t;

  typedef struct packed {
    burst_t           bytes;
    logic [IDX_W-1:0] last;
    logic             stamp;
    logic [SEC_W-1:0] secs;
  } item_t;

  function automatic logic [3:0] digit_value(input logic [7:0] b);
    logic [7:0] d;
    d = b - ZERO_CHAR;
    if (b >= ZERO_CHAR && b <= NINE_CHAR) return d[3:0];
    return 4'd0;
  endfunction

  function automatic logic [15:0] stamp_weight(input logic [IDX_W-1:0] ofs);
    logic [15:0] w;
    unique case (ofs)
      3'd0:    w = 16'd36000;
      3'd1:    w = 16'd3600;
      3'd3:    w = 16'd600;
      3'd4:    w = 16'd60;
      3'd6:    w = 16'd10;
      3'd7:    w = 16'd1;
      default: w = 16'd0;
    endcase
    return w;
  endfunction

  // two ASCII digits of a value 0..99, tens in the upper byte
  function automatic logic [15:0] dec_chars(input logic [6:0] v);
    logic [3:0] tens;
    logic [6:0] ones;
    tens = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= 7'(10 * k)) tens = tens + 4'd1;
    end
    ones = v - ({tens, 3'b000} + {2'b00, tens, 1'b0});
    return {ZERO_CHAR + {4'b0000, tens}, ZERO_CHAR + {1'b0, ones}};
  endfunction

endpackage

/* rtl/subtitle_timestamp_shifter_core.sv */
// ----------------------------------------------------------------------------
// subtitle_timestamp_shifter_core
// Shifts the HH:MM:SS timestamps of subtitle text by a configured number
// of seconds, passing all other bytes through.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   in_byte_i
//   out      output     out_valid_o/out_ready_i out_byte_o, run_last_o
//   cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// One byte per cycle in while in_ready_o is high; the first result passes
// five pipeline stages plus the result register.
// A completed timestamp yields 8 results that the result register sends
// one per cycle while out_ready_i is high; input waits until the last goes.
// Reset clears control state only; no clearing pass.
// A waiting result with out_ready_i low freezes the whole pipeline and
// drops in_ready_o.
// ----------------------------------------------------------------------------
module subtitle_timestamp_shifter_core import sts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [SEC_W-1:0] cfg_data_i
);

  logic [SEC_W-1:0] offset_q;
  logic             dir_q;

  logic             adv, take;
  logic             item_valid, conv_valid;
  item_t            item;
  burst_t           conv_bytes;
  logic [IDX_W-1:0] conv_last;

  assign in_ready_o = adv;
  assign take       = in_valid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      dir_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFFSET: offset_q <= cfg_data_i;
        CFG_DIR:    dir_q    <= cfg_data_i[0];
      endcase
    end
  end

  sts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .in_byte_i    (in_byte_i),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  sts_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .in_valid_i  (take && item_valid),
    .in_item_i   (item),
    .offset_i    (offset_q),
    .dir_i       (dir_q),
    .out_valid_o (conv_valid),
    .out_bytes_o (conv_bytes),
    .out_last_o  (conv_last)
  );

  sts_burst u_burst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (conv_valid),
    .load_bytes_i (conv_bytes),
    .load_last_i  (conv_last),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .free_o       (adv)
  );

endmodule

/* rtl/sts_front.sv */
// ----------------------------------------------------------------------------
// sts_front
// Line tracking and timestamp capture. Holds timestamp bytes, accumulates
// their weighted digit value and builds one item per transfer that yields
// output bytes.
// ----------------------------------------------------------------------------
module sts_front import sts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] in_byte_i,
  output logic       item_valid_o,
  output item_t      item_o
);

  logic [1:0]       phase_q, phase_d;
  logic [4:0]       pos_q, pos_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [SEC_W-1:0] acc_q, acc_d;
  burst_t           hold_q, hold_d;

  logic             is_nl, in_stamp, hold, done;
  logic [SEC_W-1:0] dval, wval, contrib;

  always_comb begin
    is_nl    = (in_byte_i == NEWLINE_BYTE);
    in_stamp = (pos_q <= FIRST_END) || (pos_q >= SECOND_START && pos_q <= SECOND_END);
    hold     = !is_nl && (phase_q == STAMP_PHASE) && in_stamp;
    done     = hold && (cnt_q == IDX_W'(STAMP_LEN - 1));
    dval     = {15'b0, digit_value(in_byte_i)};
    wval     = {3'b0, stamp_weight(cnt_q)};
    contrib  = dval * wval;

    hold_d        = hold_q;
    hold_d[cnt_q] = in_byte_i;

    item_o.bytes = hold_d;
    item_o.stamp = hold;
    item_o.secs  = acc_q + contrib;
    priority if (is_nl) begin
      item_o.last = cnt_q;
    end else if (hold) begin
      item_o.last = IDX_W'(STAMP_LEN - 1);
    end else begin
      item_o.last     = '0;
      item_o.bytes[0] = in_byte_i;
    end
    item_valid_o = !hold || done;

    phase_d = phase_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    if (is_nl) begin
      phase_d = phase_q + 2'd1;
      pos_d   = '0;
      cnt_d   = '0;
      acc_d   = '0;
    end else begin
      if (pos_q != POS_MAX) pos_d = pos_q + 5'd1;
      if (done) begin
        cnt_d = '0;
        acc_d = '0;
      end else if (hold) begin
        cnt_d = cnt_q + IDX_W'(1);
        acc_d = acc_q + contrib;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
      acc_q   <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && hold) hold_q <= hold_d;
  end

endmodule

/* rtl/sts_conv.sv */
// ----------------------------------------------------------------------------
// sts_conv
// In-order item pipeline. Timestamp items get the offset applied with
// clamping, are split into hours, minutes and seconds and rewritten as
// ASCII digits; other items ride along unchanged.
// ----------------------------------------------------------------------------
module sts_conv import sts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             in_valid_i,
  input  item_t            in_item_i,
  input  logic [SEC_W-1:0] offset_i,
  input  logic             dir_i,
  output logic             out_valid_o,
  output burst_t           out_bytes_o,
  output logic [IDX_W-1:0] out_last_o
);

  localparam int unsigned STAGES = 5;

  logic [STAGES-1:0] valid_q;

  item_t       s1_q, s2_q, s3_q, s4_q, s5_q;
  item_t       s2_d;
  logic [6:0]  h3_q, h4_q, h5_q;
  logic [11:0] r4_q;
  logic [5:0]  m5_q, sec5_q;

  logic [SEC_W:0]   wide, pre;
  logic [SEC_W-1:0] diff, adj, hour_secs, rem_full;
  logic [38:0]      prod_h;
  logic [24:0]      prod_m;
  logic [6:0]       h_d;
  logic [5:0]       m_d;
  logic [11:0]      sec_full;
  logic [15:0]      hc, mc, sc;

  always_comb begin
    wide = {1'b0, s1_q.secs} + {1'b0, offset_i};
    diff = s1_q.secs - offset_i;
    if (dir_i == DIR_SUB) begin
      pre = (s1_q.secs < offset_i) ? '0 : {1'b0, diff};
    end else begin
      pre = wide;
    end
    adj = (pre > {1'b0, MAX_SECONDS}) ? MAX_SECONDS : pre[SEC_W-1:0];

    s2_d      = s1_q;
    s2_d.secs = adj;

    prod_h = {20'b0, s2_q.secs} * {19'b0, HOUR_RECIP};
    h_d    = prod_h[HOUR_SHIFT+6:HOUR_SHIFT];

    hour_secs = {12'b0, h3_q} * {7'b0, SEC_PER_HOUR};
    rem_full  = s3_q.secs - hour_secs;

    prod_m   = {13'b0, r4_q} * {12'b0, MIN_RECIP};
    m_d      = prod_m[MIN_SHIFT+5:MIN_SHIFT];
    sec_full = r4_q - ({m_d, 6'b0} - {4'b0, m_d, 2'b0});

    hc = dec_chars(h5_q);
    mc = dec_chars({1'b0, m5_q});
    sc = dec_chars({1'b0, sec5_q});
    out_bytes_o = s5_q.bytes;
    if (s5_q.stamp) begin
      out_bytes_o[0] = hc[15:8];
      out_bytes_o[1] = hc[7:0];
      out_bytes_o[3] = mc[15:8];
      out_bytes_o[4] = mc[7:0];
      out_bytes_o[6] = sc[15:8];
      out_bytes_o[7] = sc[7:0];
    end
    out_last_o  = s5_q.last;
    out_valid_o = valid_q[STAGES-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q      <= in_item_i;
      s2_q      <= s2_d;
      s3_q      <= s2_q;
      h3_q      <= h_d;
      s4_q      <= s3_q;
      h4_q      <= h3_q;
      r4_q      <= rem_full[11:0];
      s5_q      <= s4_q;
      h5_q      <= h4_q;
      m5_q      <= m_d;
      sec5_q    <= sec_full[5:0];
    end
  end

endmodule

/* rtl/sts_burst.sv */
// ----------------------------------------------------------------------------
// sts_burst
// Result register. Loads up to eight bytes of one item and hands them out
// one per transfer, flagging the last one.
// ----------------------------------------------------------------------------
module sts_burst import sts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_valid_i,
  input  burst_t           load_bytes_i,
  input  logic [IDX_W-1:0] load_last_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             free_o
);

  logic             valid_q;
  logic [IDX_W-1:0] idx_q, last_q;
  burst_t           bytes_q;

  assign run_last_o  = (idx_q == last_q);
  assign out_valid_o = valid_q;
  assign out_byte_o  = bytes_q[idx_q];
  assign free_o      = !valid_q || (out_ready_i && run_last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (free_o) begin
      valid_q <= load_valid_i;
      idx_q   <= '0;
    end else if (out_ready_i) begin
      idx_q   <= idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_valid_i) begin
      bytes_q <= load_bytes_i;
      last_q  <= load_last_i;
    end
  end

endmodule

/* rtl/sts_checker.sv */
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks for the subtitle timestamp shifter, bound to the top.
// ----------------------------------------------------------------------------
module sts_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [7:0]       out_byte_o,
  input logic             run_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_byte_o) && $stable(run_last_o))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty result register");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !run_last_o |=> out_valid_o)
    else $error("run ended without last flag");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

endmodule

bind subtitle_timestamp_shifter_core sts_checker u_sts_checker (.*);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for subtitle_timestamp_shifter_core. Drives subtitle
// text byte by byte (mostly well-formed SRT blocks, plus noise, truncated
// and long lines) under several shift settings. A scoreboard predicts the
// rewritten byte stream and checks every output transfer.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sts_pkg::*;

  localparam int unsigned SEC_PER_MIN  = 60;
  localparam logic        DIR_ADD      = 1'b0;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned LONG_STALL   = 120;
  localparam int unsigned END_LIMIT    = 5000;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  class shift_scoreboard;
    logic [SEC_W-1:0] offset;
    logic             dir;
    logic [1:0]       line_phase;
    logic [4:0]       pos;
    logic [7:0]       held [STAMP_LEN];
    int unsigned      held_cnt;
    text_byte_t       expected_bytes [$];
    text_byte_t       run_bytes [$];
    int unsigned      errors, bytes_in, bytes_out, stamps, settings;

    function new();
      offset     = '0;
      dir        = DIR_ADD;
      line_phase = '0;
      pos        = '0;
      held_cnt   = 0;
      errors     = 0;
      bytes_in   = 0;
      bytes_out  = 0;
      stamps     = 0;
      settings   = 0;
    endfunction

    task report(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    function void set_shift(input logic [SEC_W-1:0] ofs, input logic d);
      offset = ofs;
      dir    = d;
      settings++;
    endfunction

    function int unsigned to_digit(input logic [7:0] b);
      if (b >= ZERO_CHAR && b <= NINE_CHAR) return int'(b - ZERO_CHAR);
      return 0;
    endfunction

    function void emit(input logic [7:0] b);
      text_byte_t e;
      e.data = b;
      e.last = 1'b0;
      run_bytes.push_back(e);
    endfunction

    function logic [7:0] digit_char(input int unsigned v);
      return ZERO_CHAR + 8'(v % 10);
    endfunction

    function void shift_stamp();
      int unsigned h, m, s, t;
      h = to_digit(held[0]) * 10 + to_digit(held[1]);
      m = to_digit(held[3]) * 10 + to_digit(held[4]);
      s = to_digit(held[6]) * 10 + to_digit(held[7]);
      t = h * SEC_PER_HOUR + m * SEC_PER_MIN + s;
      if (dir == DIR_SUB) begin
        t = (t < offset) ? 0 : t - offset;
      end else begin
        t = t + offset;
      end
      if (t > MAX_SECONDS) t = MAX_SECONDS;
      h = t / SEC_PER_HOUR;
      m = (t % SEC_PER_HOUR) / SEC_PER_MIN;
      s = t % SEC_PER_MIN;
      emit(digit_char(h / 10));
      emit(digit_char(h));
      emit(held[2]);
      emit(digit_char(m / 10));
      emit(digit_char(m));
      emit(held[5]);
      emit(digit_char(s / 10));
      emit(digit_char(s));
      stamps++;
    endfunction

    function void accept_byte(input logic [7:0] b);
      bit in_stamp;
      run_bytes.delete();
      bytes_in++;
      if (b == NEWLINE_BYTE) begin
        for (int i = 0; i < held_cnt; i++) emit(held[i]);
        emit(b);
        held_cnt   = 0;
        pos        = '0;
        line_phase = line_phase + 2'd1;
      end else begin
        in_stamp = (pos <= FIRST_END) || (pos >= SECOND_START && pos <= SECOND_END);
        if (line_phase == STAMP_PHASE && in_stamp) begin
          held[held_cnt % STAMP_LEN] = b;
          held_cnt++;
          if (held_cnt >= STAMP_LEN) begin
            shift_stamp();
            held_cnt = 0;
          end
        end else begin
          emit(b);
        end
        if (pos < POS_MAX) pos = pos + 5'd1;
      end
      if (run_bytes.size() > 0) run_bytes[run_bytes.size() - 1].last = 1'b1;
      foreach (run_bytes[i]) expected_bytes.push_back(run_bytes[i]);
    endfunction

    task check_byte(input logic [7:0] b, input logic last);
      text_byte_t e;
      bytes_out++;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected output byte %02h", b));
      end else begin
        e = expected_bytes.pop_front();
        if (b !== e.data)
          report($sformatf("out_byte %02h, expected %02h (output %0d)", b, e.data, bytes_out));
        if (last !== e.last)
          report($sformatf("run_last %b, expected %b (output %0d)", last, e.last, bytes_out));
      end
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [7:0]       in_byte_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [7:0]       out_byte_o;
  logic             run_last_o;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [SEC_W-1:0] cfg_data_i;

  shift_scoreboard sb;
  bit              idle_en;
  bit              long_stall_req;

  subtitle_timestamp_shifter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("Timeout: run did not finish");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_byte(out_byte_o, run_last_o);
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned n;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_stall_req) begin
        out_ready_i <= 1'b0;
        repeat (LONG_STALL) @(posedge clk_i);
        long_stall_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        n = $urandom_range(1, 12);
        do begin
          @(posedge clk_i);
          n--;
        end while (n != 0 && !long_stall_req);
      end
    end
  end

  task automatic write_shift(input logic [SEC_W-1:0] ofs, input logic d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_OFFSET;
    cfg_data_i <= ofs;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_DIR;
    cfg_data_i <= {{(SEC_W-1){1'b0}}, d};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_shift(ofs, d);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.accept_byte(b);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_noise(input int unsigned n, input bit printable);
    for (int i = 0; i < n; i++)
      send_byte(printable ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255)));
  endtask

  task automatic send_digits(input int unsigned n);
    for (int i = 0; i < n; i++) send_byte(ZERO_CHAR + 8'($urandom_range(0, 9)));
  endtask

  // HH:MM:SS with occasional junk in digit or separator slots
  task automatic send_stamp();
    for (int k = 0; k < STAMP_LEN; k++) begin
      if (k == 2 || k == 5)
        send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : ":");
      else if ($urandom_range(0, 14) == 0)
        send_byte(8'($urandom_range(0, 255)));
      else
        send_byte(ZERO_CHAR + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic send_line();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (sb.line_phase == STAMP_PHASE && kind < 8) begin
      send_stamp();
      send_text(",");
      send_digits(3);
      send_text(" --> ");
      send_stamp();
      send_text(",");
      send_digits(3);
      if (kind == 0) send_noise($urandom_range(1, 12), 1'b1);
    end else if (kind >= 8) begin
      send_noise($urandom_range(0, 40), 1'b0);
    end else begin
      send_noise($urandom_range(0, 6), 1'b1);
    end
    send_byte(NEWLINE_BYTE);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_lines(input int unsigned min_bytes, input bit pause);
    int unsigned start;
    start = sb.bytes_in;
    send_line();
    if (pause) begin
      in_valid_i <= 1'b0;
      while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    end
    while (sb.bytes_in - start < min_bytes) send_line();
    wait_drained();
  endtask

  initial begin
    int unsigned n;
    sb             = new();
    idle_en        = 1'b1;
    long_stall_req = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_byte_i      = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_OFFSET;
    cfg_data_i     = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // saturation, non-digit, early line end, byte extremes
    write_shift(MAX_SECONDS, DIR_ADD);
    send_text("\n0a:00:01\n\n\n\n12:3\n");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("\n\n");
    wait_drained();

    // clamp at zero, non-colon separators
    write_shift(19'd1, DIR_SUB);
    send_text("\n00.00.00\n\n\n");
    wait_drained();

    write_shift('0, DIR_ADD);
    run_lines(10, 1'b1);

    write_shift('1, DIR_SUB);
    long_stall_req = 1'b1;
    run_lines(24, 1'b0);

    write_shift('1, DIR_ADD);
    run_lines(10, 1'b0);

    write_shift(SEC_W'($urandom_range(0, 7200)), 1'($urandom_range(0, 1)));
    run_lines(10, 1'b0);

    idle_en = 1'b0;
    write_shift(SEC_W'($urandom_range(0, 524287)), 1'($urandom_range(0, 1)));
    run_lines(10, 1'b0);

    n = 0;
    while (sb.expected_bytes.size() != 0 && n < END_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    if (sb.expected_bytes.size() != 0)
      sb.report($sformatf("%0d expected output bytes never arrived", sb.expected_bytes.size()));
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run: %0d bytes in, %0d bytes out, %0d timestamps shifted, %0d shift settings",
             sb.bytes_in, sb.bytes_out, sb.stamps, sb.settings);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
